>>> hw/rtl/ogl_pkg.sv
// Shared constants, command and status types for the order group linkage table.
package ogl_pkg;

   localparam int LINK_SLOTS_DEF    = 256;
   localparam int GROUP_SLOTS_DEF   = 64;
   localparam int GROUP_MEMBERS_DEF = 8;

   localparam int KIND_W     = 2;
   localparam int ORDER_ID_W = 64;
   localparam int STATUS_W   = 2;
   localparam int GROUP_ID_W = 32;
   localparam int ACTIVE_W   = 7;
   localparam int MIN_MEMBERS = 2;

   localparam logic [KIND_W-1:0] KIND_REGISTER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EXECUTED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CANCELED = 2'd2;
   localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_GROUP   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_LINKED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NO_ROOM    = 2'd3;

   typedef logic [3:0] op_type;

   localparam op_type OP_IDLE   = 4'd0;
   localparam op_type OP_FIND   = 4'd1;
   localparam op_type OP_PACK   = 4'd2;
   localparam op_type OP_GSCAN  = 4'd3;
   localparam op_type OP_ALLOC  = 4'd4;
   localparam op_type OP_FORM   = 4'd5;
   localparam op_type OP_SIB    = 4'd6;
   localparam op_type OP_CLOSE  = 4'd7;
   localparam op_type OP_UNLINK = 4'd8;
   localparam op_type OP_SIZE   = 4'd9;
   localparam op_type OP_FREE   = 4'd10;

   typedef struct packed {
      logic                ready;
      logic                take;
      op_type              op;
      logic                rsp_load;
      logic [STATUS_W-1:0] rsp_status;
      logic                rsp_sib;
   } ogl_cmd_type;

   typedef struct packed {
      logic              take_open;
      logic              scan_done;
      logic              found;
      logic [KIND_W-1:0] kind;
      logic              overflow;
      logic              few_members;
      logic              room_ok;
      logic              size_small;
      logic              rsp_free;
      logic              sib_last;
      logic              sib_none;
   } ogl_status_type;

endpackage

>>> hw/rtl/ogl_req_if.sv
// Request channel interface: valid/ready handshake with the item payload.
interface ogl_req_if;
   logic                          valid;
   logic                          ready;
   logic [ogl_pkg::KIND_W-1:0]     kind;
   logic [ogl_pkg::ORDER_ID_W-1:0] order_id;
   logic                          last;

   modport source(output valid, kind, order_id, last, input ready);
   modport sink(input valid, kind, order_id, last, output ready);
endinterface

>>> hw/rtl/ogl_rsp_if.sv
// Response channel interface: valid/ready handshake with the result payload.
interface ogl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ogl_pkg::STATUS_W-1:0]   status;
   logic [ogl_pkg::GROUP_ID_W-1:0] group_id;
   logic [ogl_pkg::ORDER_ID_W-1:0] sibling_id;
   logic                          sibling_valid;
   logic                          linked;
   logic [ogl_pkg::ACTIVE_W-1:0]   active_groups;
   logic                          end_of_run;

   modport source(output valid, status, group_id, sibling_id, sibling_valid, linked,
                  active_groups, end_of_run, input ready);
   modport sink(input valid, status, group_id, sibling_id, sibling_valid, linked,
                active_groups, end_of_run, output ready);
endinterface

>>> hw/rtl/ogl_ctrl.sv
// Sequencer that steps each item through the table scans and response phases.
module ogl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  ogl_pkg::ogl_status_type st,
   output ogl_pkg::ogl_cmd_type    cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_FIND   = 4'd1;
   localparam logic [3:0] S_PACK   = 4'd2;
   localparam logic [3:0] S_GSCAN  = 4'd3;
   localparam logic [3:0] S_ALLOC  = 4'd4;
   localparam logic [3:0] S_FORM   = 4'd5;
   localparam logic [3:0] S_SIB    = 4'd6;
   localparam logic [3:0] S_CLOSE  = 4'd7;
   localparam logic [3:0] S_UNLINK = 4'd8;
   localparam logic [3:0] S_SIZE   = 4'd9;
   localparam logic [3:0] S_FREE   = 4'd10;
   localparam logic [3:0] S_RESP   = 4'd11;
   localparam logic [3:0] S_EMIT   = 4'd12;

   logic [3:0]                    state_ff, state_in;
   logic [ogl_pkg::STATUS_W-1:0]  code_ff, code_in;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.ready = 1'b1;
            cmd.take  = req_valid;
            if (req_valid && !st.take_open) begin
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            cmd.op = ogl_pkg::OP_FIND;
            if (st.scan_done) begin
               unique case (st.kind)
                  ogl_pkg::KIND_REGISTER: begin
                     if (st.overflow) begin
                        code_in  = ogl_pkg::STATUS_NO_ROOM;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_PACK;
                     end
                  end
                  ogl_pkg::KIND_EXECUTED: begin
                     code_in  = ogl_pkg::STATUS_NOT_LINKED;
                     state_in = st.found ? S_SIB : S_RESP;
                  end
                  ogl_pkg::KIND_CANCELED: begin
                     code_in  = ogl_pkg::STATUS_NOT_LINKED;
                     state_in = st.found ? S_UNLINK : S_RESP;
                  end
                  default: begin
                     code_in  = st.found ? ogl_pkg::STATUS_DONE : ogl_pkg::STATUS_NOT_LINKED;
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_PACK: begin
            cmd.op = ogl_pkg::OP_PACK;
            if (st.scan_done) begin
               if (st.few_members) begin
                  code_in  = ogl_pkg::STATUS_NO_GROUP;
                  state_in = S_RESP;
               end else begin
                  state_in = S_GSCAN;
               end
            end
         end
         S_GSCAN: begin
            cmd.op = ogl_pkg::OP_GSCAN;
            if (st.scan_done) begin
               if (st.room_ok) begin
                  state_in = S_ALLOC;
               end else begin
                  code_in  = ogl_pkg::STATUS_NO_ROOM;
                  state_in = S_RESP;
               end
            end
         end
         S_ALLOC: begin
            cmd.op = ogl_pkg::OP_ALLOC;
            if (st.scan_done) begin
               state_in = S_FORM;
            end
         end
         S_FORM: begin
            cmd.op   = ogl_pkg::OP_FORM;
            code_in  = ogl_pkg::STATUS_DONE;
            state_in = S_RESP;
         end
         S_SIB: begin
            cmd.op = ogl_pkg::OP_SIB;
            if (st.scan_done) begin
               state_in = S_CLOSE;
            end
         end
         S_CLOSE: begin
            cmd.op   = ogl_pkg::OP_CLOSE;
            code_in  = ogl_pkg::STATUS_DONE;
            state_in = (st.kind == ogl_pkg::KIND_EXECUTED) ? S_EMIT : S_RESP;
         end
         S_UNLINK: begin
            cmd.op   = ogl_pkg::OP_UNLINK;
            state_in = S_SIZE;
         end
         S_SIZE: begin
            cmd.op   = ogl_pkg::OP_SIZE;
            code_in  = ogl_pkg::STATUS_DONE;
            state_in = st.size_small ? S_FREE : S_RESP;
         end
         S_FREE: begin
            cmd.op = ogl_pkg::OP_FREE;
            if (st.scan_done) begin
               state_in = S_CLOSE;
            end
         end
         S_RESP: begin
            cmd.rsp_status = code_ff;
            if (st.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_EMIT: begin
            cmd.rsp_status = ogl_pkg::STATUS_DONE;
            if (st.rsp_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sib  = !st.sib_none;
               if (st.sib_none || st.sib_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ogl_pkg::STATUS_DONE;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

>>> hw/rtl/ogl_datapath.sv
// Link slot table, group table, pending run and response register.
module ogl_datapath #(
   parameter int LINK_SLOTS    = ogl_pkg::LINK_SLOTS_DEF,
   parameter int GROUP_SLOTS   = ogl_pkg::GROUP_SLOTS_DEF,
   parameter int GROUP_MEMBERS = ogl_pkg::GROUP_MEMBERS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ogl_pkg::KIND_W-1:0]     req_kind,
   input  logic [ogl_pkg::ORDER_ID_W-1:0] req_order_id,
   input  logic                          req_last,
   input  ogl_pkg::ogl_cmd_type           cmd,
   output ogl_pkg::ogl_status_type        st,
   ogl_rsp_if.source                     rsp_chan
);

   localparam int IDW  = ogl_pkg::ORDER_ID_W;
   localparam int SW   = $clog2(LINK_SLOTS);
   localparam int GW   = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
   localparam int MW   = $clog2(GROUP_MEMBERS);
   localparam int CW   = $clog2(GROUP_MEMBERS + 1);
   localparam int UW   = $clog2(LINK_SLOTS + 1);
   localparam int LW   = $clog2(GROUP_SLOTS + 1);
   localparam int MAXD = (LINK_SLOTS > GROUP_SLOTS) ? LINK_SLOTS : GROUP_SLOTS;
   localparam int PW   = $clog2(MAXD + 1);

   // Control state.
   logic [PW-1:0]               ptr_ff;
   logic                        pv_ff;
   logic [LINK_SLOTS-1:0]       slot_used_ff, slot_used_in;
   logic [GROUP_SLOTS-1:0]      group_live_ff;
   logic [UW-1:0]               used_count_ff, used_count_in;
   logic [LW-1:0]               live_count_ff;
   logic [ogl_pkg::GROUP_ID_W-1:0] next_gnum_ff;
   logic [CW-1:0]               pcount_ff;
   logic                        overflow_ff;
   logic                        found_ff;
   logic [GROUP_MEMBERS-1:0]    lmask_ff;
   logic [CW-1:0]               n_ff, ai_ff, k_ff, eidx_ff;
   logic                        gfound_ff;
   logic                        rsp_valid_ff;

   // Payload state.
   logic [ogl_pkg::KIND_W-1:0]  kind_ff;
   logic [IDW-1:0]              id_ff;
   logic [IDW-1:0]              pend_ff [GROUP_MEMBERS];
   logic [IDW-1:0]              kept_ff [GROUP_MEMBERS];
   logic [IDW-1:0]              sib_ff  [GROUP_MEMBERS];
   logic [SW-1:0]               idx_ff, fslot_ff;
   logic [GW-1:0]               fgrp_ff, gsel_ff;
   logic [IDW-1:0]              ord_q_ff;
   logic [GW-1:0]               grp_q_ff;
   logic [CW-1:0]               size_q_ff;
   logic [ogl_pkg::GROUP_ID_W-1:0] gnum_ff;

   logic [IDW-1:0]              order_mem [LINK_SLOTS];
   logic [GW-1:0]               group_mem [LINK_SLOTS];
   logic [CW-1:0]               size_mem  [GROUP_SLOTS];

   logic                        op_find, op_pack, op_gscan, op_alloc, op_form;
   logic                        op_sib, op_close, op_unlink, op_size, op_free;
   logic                        mem_scan, any_scan, scan_done;
   logic [PW-1:0]               limit;
   logic                        in_slots, in_groups, in_members;
   logic [SW-1:0]               pslot;
   logic [GW-1:0]               pgrp;
   logic [MW-1:0]               pmem;
   logic                        s2, used2, grp_hit, clr_scan, alloc_wr, id_hit;
   logic [IDW-1:0]              cand;
   logic                        dup, keep_ok;
   logic [CW-1:0]               size_new;
   logic [ogl_pkg::GROUP_ID_W-1:0] gnum_inc;
   logic                        rsp_free;

   assign op_find   = (cmd.op == ogl_pkg::OP_FIND);
   assign op_pack   = (cmd.op == ogl_pkg::OP_PACK);
   assign op_gscan  = (cmd.op == ogl_pkg::OP_GSCAN);
   assign op_alloc  = (cmd.op == ogl_pkg::OP_ALLOC);
   assign op_form   = (cmd.op == ogl_pkg::OP_FORM);
   assign op_sib    = (cmd.op == ogl_pkg::OP_SIB);
   assign op_close  = (cmd.op == ogl_pkg::OP_CLOSE);
   assign op_unlink = (cmd.op == ogl_pkg::OP_UNLINK);
   assign op_size   = (cmd.op == ogl_pkg::OP_SIZE);
   assign op_free   = (cmd.op == ogl_pkg::OP_FREE);

   assign mem_scan = op_find || op_sib || op_free;
   assign any_scan = mem_scan || op_alloc || op_gscan || op_pack;

   always_comb begin
      if (op_gscan) begin
         limit = PW'(GROUP_SLOTS);
      end else if (op_pack) begin
         limit = PW'(GROUP_MEMBERS);
      end else begin
         limit = PW'(LINK_SLOTS);
      end
   end

   assign scan_done  = any_scan && (ptr_ff == limit);
   assign in_slots   = (ptr_ff < PW'(LINK_SLOTS));
   assign in_groups  = (ptr_ff < PW'(GROUP_SLOTS));
   assign in_members = (ptr_ff < PW'(GROUP_MEMBERS));
   assign pslot      = ptr_ff[SW-1:0];
   assign pgrp       = ptr_ff[GW-1:0];
   assign pmem       = ptr_ff[MW-1:0];

   // Second stage of the pipelined slot scans.
   assign s2       = pv_ff && mem_scan;
   assign used2    = slot_used_ff[idx_ff];
   assign grp_hit  = s2 && used2 && (grp_q_ff == fgrp_ff);
   assign clr_scan = grp_hit && (op_sib || op_free);
   assign id_hit   = s2 && op_find && used2 && (ord_q_ff == id_ff);

   assign alloc_wr = op_alloc && in_slots && !slot_used_ff[pslot] && (ai_ff < n_ff);

   assign cand = pend_ff[pmem];
   always_comb begin
      dup = 1'b0;
      for (int j = 0; j < GROUP_MEMBERS; j++) begin
         if ((CW'(j) < n_ff) && (kept_ff[j] == cand)) begin
            dup = 1'b1;
         end
      end
   end
   assign keep_ok = op_pack && in_members && (CW'(pmem) < pcount_ff) && !lmask_ff[pmem] && !dup;

   assign size_new = (size_q_ff != '0) ? (size_q_ff - CW'(1)) : size_q_ff;
   assign gnum_inc = (next_gnum_ff == '1) ? ogl_pkg::GROUP_ID_W'(1) :
                     next_gnum_ff + ogl_pkg::GROUP_ID_W'(1);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      slot_used_in  = slot_used_ff;
      used_count_in = used_count_ff;
      if (alloc_wr) begin
         slot_used_in[pslot] = 1'b1;
         used_count_in       = used_count_ff + UW'(1);
      end
      if (clr_scan) begin
         slot_used_in[idx_ff] = 1'b0;
         used_count_in        = used_count_ff - UW'(1);
      end
      if (op_unlink) begin
         slot_used_in[fslot_ff] = 1'b0;
         used_count_in          = used_count_ff - UW'(1);
      end
   end

   // Link slot memories.
   always_ff @(posedge clock) begin
      if (alloc_wr) begin
         order_mem[pslot] <= kept_ff[ai_ff[MW-1:0]];
         group_mem[pslot] <= gsel_ff;
      end
      ord_q_ff <= order_mem[pslot];
      grp_q_ff <= group_mem[pslot];
   end

   // Group size memory.
   always_ff @(posedge clock) begin
      if (op_form) begin
         size_mem[gsel_ff] <= n_ff;
      end else if (op_size) begin
         size_mem[fgrp_ff] <= size_new;
      end
      size_q_ff <= size_mem[fgrp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff        <= '0;
         pv_ff         <= 1'b0;
         slot_used_ff  <= '0;
         group_live_ff <= '0;
         used_count_ff <= '0;
         live_count_ff <= '0;
         next_gnum_ff  <= ogl_pkg::GROUP_ID_W'(1);
         pcount_ff     <= '0;
         overflow_ff   <= 1'b0;
         found_ff      <= 1'b0;
         lmask_ff      <= '0;
         n_ff          <= '0;
         ai_ff         <= '0;
         k_ff          <= '0;
         eidx_ff       <= '0;
         gfound_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slot_used_ff  <= slot_used_in;
         used_count_ff <= used_count_in;
         pv_ff         <= mem_scan && in_slots;
         if (any_scan) begin
            ptr_ff <= scan_done ? '0 : ptr_ff + PW'(1);
         end
         if (cmd.take) begin
            found_ff  <= 1'b0;
            lmask_ff  <= '0;
            n_ff      <= '0;
            ai_ff     <= '0;
            k_ff      <= '0;
            eidx_ff   <= '0;
            gfound_ff <= 1'b0;
            if (req_kind == ogl_pkg::KIND_REGISTER) begin
               if (pcount_ff < CW'(GROUP_MEMBERS)) begin
                  pcount_ff <= pcount_ff + CW'(1);
               end else begin
                  overflow_ff <= 1'b1;
               end
            end
         end
         if (s2 && op_find && used2) begin
            if (ord_q_ff == id_ff) begin
               found_ff <= 1'b1;
            end
            for (int i = 0; i < GROUP_MEMBERS; i++) begin
               if (ord_q_ff == pend_ff[i]) begin
                  lmask_ff[i] <= 1'b1;
               end
            end
         end
         if (keep_ok) begin
            n_ff <= n_ff + CW'(1);
         end
         if (op_gscan && in_groups && !group_live_ff[pgrp] && !gfound_ff) begin
            gfound_ff <= 1'b1;
         end
         if (alloc_wr) begin
            ai_ff <= ai_ff + CW'(1);
         end
         if (op_form) begin
            group_live_ff[gsel_ff] <= 1'b1;
            live_count_ff          <= live_count_ff + LW'(1);
            next_gnum_ff           <= gnum_inc;
         end
         if (clr_scan && op_sib && (idx_ff != fslot_ff) &&
             (k_ff < CW'(GROUP_MEMBERS - 1))) begin
            k_ff <= k_ff + CW'(1);
         end
         if (op_close) begin
            group_live_ff[fgrp_ff] <= 1'b0;
            if (live_count_ff != '0) begin
               live_count_ff <= live_count_ff - LW'(1);
            end
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
            if (cmd.rsp_sib) begin
               eidx_ff <= eidx_ff + CW'(1);
            end
            if (kind_ff == ogl_pkg::KIND_REGISTER) begin
               pcount_ff   <= '0;
               overflow_ff <= 1'b0;
            end
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff <= pslot;
      if (cmd.take) begin
         kind_ff <= req_kind;
         id_ff   <= req_order_id;
         if ((req_kind == ogl_pkg::KIND_REGISTER) && (pcount_ff < CW'(GROUP_MEMBERS))) begin
            pend_ff[pcount_ff[MW-1:0]] <= req_order_id;
         end
      end
      if (s2 && op_find && used2 && (ord_q_ff == id_ff) && !found_ff) begin
         fslot_ff <= idx_ff;
         fgrp_ff  <= grp_q_ff;
      end
      if (keep_ok) begin
         kept_ff[n_ff[MW-1:0]] <= cand;
      end
      if (op_gscan && in_groups && !group_live_ff[pgrp] && !gfound_ff) begin
         gsel_ff <= pgrp;
      end
      if (op_form) begin
         gnum_ff <= next_gnum_ff;
      end
      if (clr_scan && op_sib && (idx_ff != fslot_ff) &&
          (k_ff < CW'(GROUP_MEMBERS - 1))) begin
         sib_ff[k_ff[MW-1:0]] <= ord_q_ff;
      end
      if (cmd.rsp_load) begin
         rsp_chan.status        <= cmd.rsp_status;
         rsp_chan.group_id      <= ((kind_ff == ogl_pkg::KIND_REGISTER) &&
                                    (cmd.rsp_status == ogl_pkg::STATUS_DONE)) ? gnum_ff : '0;
         rsp_chan.sibling_id    <= cmd.rsp_sib ? sib_ff[eidx_ff[MW-1:0]] : '0;
         rsp_chan.sibling_valid <= cmd.rsp_sib;
         rsp_chan.linked        <= found_ff;
         rsp_chan.active_groups <= ogl_pkg::ACTIVE_W'(live_count_ff);
         rsp_chan.end_of_run    <= cmd.rsp_sib ? (eidx_ff + CW'(1) == k_ff) : 1'b1;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;

   assign st.take_open   = (req_kind == ogl_pkg::KIND_REGISTER) && !req_last;
   assign st.scan_done   = scan_done;
   assign st.found       = found_ff || id_hit;
   assign st.kind        = kind_ff;
   assign st.overflow    = overflow_ff;
   assign st.few_members = (n_ff < CW'(ogl_pkg::MIN_MEMBERS));
   assign st.room_ok     = gfound_ff &&
                           ((UW + 1)'(used_count_ff) + (UW + 1)'(n_ff) <= (UW + 1)'(LINK_SLOTS));
   assign st.size_small  = (size_new < CW'(ogl_pkg::MIN_MEMBERS));
   assign st.rsp_free    = rsp_free;
   assign st.sib_last    = (eidx_ff + CW'(1) == k_ff);
   assign st.sib_none    = (k_ff == '0);

endmodule

>>> hw/rtl/oco_group_linkage_table.sv
// Top level of the one-cancels-other order group linkage table.
//
//   Channel   Dir  Carries
//   req_chan  in   kind, order_id, last
//   rsp_chan  out  status, group_id, sibling_id, sibling_valid, linked,
//                  active_groups, end_of_run
//
// A query takes the item, runs the pipelined slot scan and loads the result. A cancel
// unlinks the order, shrinks its group and, when too few members remain, dissolves
// it with a further slot scan; an execution scans out the siblings and emits one
// result per sibling. A run that forms a group packs the run, scans for a free group,
// allocates slots and forms it; a registration item that is not last is only taken.
// Reset is synchronous with no clearing pass; a stalled result holds the block.
module oco_group_linkage_table #(
   parameter int LINK_SLOTS    = ogl_pkg::LINK_SLOTS_DEF,
   parameter int GROUP_SLOTS   = ogl_pkg::GROUP_SLOTS_DEF,
   parameter int GROUP_MEMBERS = ogl_pkg::GROUP_MEMBERS_DEF
) (
   input logic       clock,
   input logic       reset,
   ogl_req_if.sink   req_chan,
   ogl_rsp_if.source rsp_chan
);

   ogl_pkg::ogl_cmd_type    cmd;
   ogl_pkg::ogl_status_type st;

   assign req_chan.ready = cmd.ready;

   ogl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .st        (st),
      .cmd       (cmd)
   );

   ogl_datapath #(
      .LINK_SLOTS    (LINK_SLOTS),
      .GROUP_SLOTS   (GROUP_SLOTS),
      .GROUP_MEMBERS (GROUP_MEMBERS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_kind     (req_chan.kind),
      .req_order_id (req_chan.order_id),
      .req_last     (req_chan.last),
      .cmd          (cmd),
      .st           (st),
      .rsp_chan     (rsp_chan)
   );

endmodule
